[hw/rtl/bcdcd_pkg.sv]
// shared types, constants and helper functions for the countdown clock display
// no dependencies; imported by every module of the block
`default_nettype none

package bcdcd_pkg;

    localparam int SWITCH_COUNT_DEF = 10;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [15:0] MINSEC_RESET = 16'h5957;
    localparam logic [15:0] MINSEC_WRAP = 16'h5959;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    localparam logic [7:0] TPS_RESET = 8'd10;
    localparam logic [3:0] SELECT_RESET = 4'd1;
    localparam logic [3:0] STEP_RESET = 4'd3;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    localparam logic OP_TIMER = 1'b0;
    localparam logic OP_SWITCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SECOND = 2'd0,
        CFG_SWITCH_SELECT = 2'd1,
        CFG_SWITCH_STEP = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [3:0] switch_select;
        logic [3:0] switch_step;
    } cfg_t;

    typedef struct packed {
        logic [15:0] minsec;
        logic [4:0] hour;
    } clock_time_t;

    typedef struct packed {
        logic has_result;
        clock_time_t tm;
    } tk_result_t;

    // active-low segments, bit 7 is the decimal point
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0: seg = 8'hC0;
            4'd1: seg = 8'hF9;
            4'd2: seg = 8'hA4;
            4'd3: seg = 8'hB0;
            4'd4: seg = 8'h99;
            4'd5: seg = 8'h92;
            4'd6: seg = 8'h82;
            4'd7: seg = 8'hF8;
            4'd8: seg = 8'h80;
            4'd9: seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // 0..59 to two bcd digits
    function automatic logic [7:0] sec_to_bcd(input logic [6:0] s);
        logic [3:0] tens;
        logic [6:0] rem;
        priority if (s >= 7'd50) begin
            tens = 4'd5;
            rem = s - 7'd50;
        end
        else if (s >= 7'd40) begin
            tens = 4'd4;
            rem = s - 7'd40;
        end
        else if (s >= 7'd30) begin
            tens = 4'd3;
            rem = s - 7'd30;
        end
        else if (s >= 7'd20) begin
            tens = 4'd2;
            rem = s - 7'd20;
        end
        else if (s >= 7'd10) begin
            tens = 4'd1;
            rem = s - 7'd10;
        end
        else begin
            tens = 4'd0;
            rem = s;
        end
        return {tens, rem[3:0]};
    endfunction

    // hour split into tens and ones
    function automatic logic [7:0] hour_to_bcd(input logic [4:0] h);
        logic [3:0] tens;
        logic [4:0] rem;
        priority if (h >= 5'd30) begin
            tens = 4'd3;
            rem = h - 5'd30;
        end
        else if (h >= 5'd20) begin
            tens = 4'd2;
            rem = h - 5'd20;
        end
        else if (h >= 5'd10) begin
            tens = 4'd1;
            rem = h - 5'd10;
        end
        else begin
            tens = 4'd0;
            rem = h;
        end
        return {tens, rem[3:0]};
    endfunction

    // subtract step seconds (0..15), borrowing a minute and then an hour
    function automatic clock_time_t sub_seconds(input clock_time_t t, input logic [3:0] step);
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
        logic [6:0] sec;
        logic [6:0] sec_new;
        logic borrow;
        clock_time_t r;
        d0 = t.minsec[3:0];
        d1 = t.minsec[7:4];
        d2 = t.minsec[11:8];
        d3 = t.minsec[15:12];
        sec = {d1, 3'b000} + {2'b00, d1, 1'b0} + {3'b000, d0};
        borrow = (sec < {3'b000, step});
        sec_new = borrow ? (sec + 7'd60 - {3'b000, step}) : (sec - {3'b000, step});
        r.hour = t.hour;
        if (borrow) begin
            if (d2 != 4'd0) begin
                d2 = d2 - 4'd1;
            end
            else if (d3 != 4'd0) begin
                d2 = 4'd9;
                d3 = d3 - 4'd1;
            end
            else begin
                d3 = MINSEC_WRAP[15:12];
                d2 = MINSEC_WRAP[11:8];
                r.hour = (t.hour == 5'd0) ? HOUR_MAX : t.hour - 5'd1;
            end
        end
        r.minsec = {d3, d2, sec_to_bcd(sec_new)};
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bcdcd_cfg.sv]
// configuration registers of the countdown clock display
// depends on bcdcd_pkg
`default_nettype none

module bcdcd_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bcdcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcdcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bcdcd_pkg::cfg_t                         cfg
);
    import bcdcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TICKS_PER_SECOND: cfg_next.ticks_per_second = cfg_data;
                CFG_SWITCH_SELECT:    cfg_next.switch_select = cfg_data[3:0];
                CFG_SWITCH_STEP:      cfg_next.switch_step = cfg_data[3:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_second <= TPS_RESET;
            cfg_reg.switch_select <= SELECT_RESET;
            cfg_reg.switch_step <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/bcdcd_timekeep.sv]
// countdown state (prescaler, minutes:seconds, hour) and the decrement logic
// depends on bcdcd_pkg
`default_nettype none

module bcdcd_timekeep #(
    parameter int SWITCH_COUNT = bcdcd_pkg::SWITCH_COUNT_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bcdcd_pkg::cfg_t         cfg,
    input  wire logic                    operation,
    input  wire logic                    timer_pending,
    input  wire logic [SWITCH_COUNT-1:0] switch_edges,
    input  wire logic                    upd,
    output bcdcd_pkg::tk_result_t        res
);
    import bcdcd_pkg::*;

    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    clock_time_t time_reg;
    clock_time_t time_next;

    logic [7:0] tick_inc;
    logic       sel_bit;
    logic       timer_hit;
    logic       switch_hit;
    logic [3:0] step;

    always_comb
    begin
        tick_inc = tick_count_reg + 8'd1;
        // select beyond the switches matches nothing
        sel_bit = 1'b0;
        for (int i = 0; i < SWITCH_COUNT; i++)
        begin
            if (32'(cfg.switch_select) == i)
            begin
                sel_bit = switch_edges[i];
            end
        end
        timer_hit = (operation == OP_TIMER) && timer_pending
                    && (tick_inc == cfg.ticks_per_second);
        switch_hit = (operation == OP_SWITCH) && sel_bit;
        step = (operation == OP_SWITCH) ? cfg.switch_step : 4'd1;

        res.has_result = timer_hit || switch_hit;
        res.tm = res.has_result ? sub_seconds(time_reg, step) : time_reg;

        tick_count_next = tick_count_reg;
        time_next = time_reg;
        if (upd)
        begin
            if ((operation == OP_TIMER) && timer_pending)
            begin
                tick_count_next = timer_hit ? 8'd0 : tick_inc;
            end
            time_next = res.tm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 8'd0;
            time_reg.minsec <= MINSEC_RESET;
            time_reg.hour <= 5'd0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            time_reg <= time_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bcdcd_display.sv]
// result register: seven-segment encoding of the new time and the output handshake
// depends on bcdcd_pkg
`default_nettype none

module bcdcd_display (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire bcdcd_pkg::clock_time_t  tm,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [7:0]                   seg_sec_ones,
    output logic [7:0]                   seg_sec_tens,
    output logic [7:0]                   seg_min_ones,
    output logic [7:0]                   seg_min_tens,
    output logic [7:0]                   seg_hour_ones,
    output logic [7:0]                   seg_hour_tens,
    output logic [15:0]                  time_bcd,
    output logic [4:0]                   hour_value
);
    import bcdcd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  seg_reg [6];
    logic [15:0] time_reg;
    logic [4:0]  hour_reg;
    logic [7:0]  hour_bcd;

    assign hour_bcd = hour_to_bcd(tm.hour);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg[0] <= seg_of(tm.minsec[3:0]);
            seg_reg[1] <= seg_of(tm.minsec[7:4]);
            seg_reg[2] <= seg_of(tm.minsec[11:8]);
            seg_reg[3] <= seg_of(tm.minsec[15:12]);
            seg_reg[4] <= seg_of(hour_bcd[3:0]);
            seg_reg[5] <= seg_of(hour_bcd[7:4]);
            time_reg <= tm.minsec;
            hour_reg <= tm.hour;
        end
    end

    assign out_valid = valid_reg;
    assign seg_sec_ones = seg_reg[0];
    assign seg_sec_tens = seg_reg[1];
    assign seg_min_ones = seg_reg[2];
    assign seg_min_tens = seg_reg[3];
    assign seg_hour_ones = seg_reg[4];
    assign seg_hour_tens = seg_reg[5];
    assign time_bcd = time_reg;
    assign hour_value = hour_reg;

endmodule

`default_nettype wire

[hw/rtl/bcd_countdown_clock_display.sv]
// top level of the countdown clock display: input register, timekeeping, result register
// depends on bcdcd_pkg, bcdcd_cfg, bcdcd_timekeep, bcdcd_display
//
// usage
//   input channel (in_valid / in_stall): one event per item, operation selects a timer
//   tick or a switch event; an item is taken when in_valid is high and in_stall low.
//   output channel (out_valid / out_stall): one item per event that decrements the
//   time, carrying six active-low digit patterns, the bcd minutes:seconds and the hour.
//   events that do not decrement (no pending flag, prescaler not yet full, unselected
//   switch) give no output item; of these only a pending timer tick counts the prescaler.
//   config port: cfg_we with cfg_index and cfg_data, written while the block is idle.
// path: an event passes the input register, then the result register, which holds its output
// item; the decrement is combinational logic between the two.
// throughput: one event per cycle while in_stall is low; the state is updated as an event
// leaves the input register, so the next event sees it with no gap.
// stall: a stalled output item holds; events that give no output keep flowing, and
// an event that would give one waits in the input register, raising in_stall.
// reset: time 59:57, hour 0, prescaler 0, registers to their defaults, both channels empty.
`default_nettype none

module bcd_countdown_clock_display #(
    parameter int SWITCH_COUNT = bcdcd_pkg::SWITCH_COUNT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 operation,
    input  wire logic                                 timer_pending,
    input  wire logic [SWITCH_COUNT-1:0]              switch_edges,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [7:0]                                seg_sec_ones,
    output logic [7:0]                                seg_sec_tens,
    output logic [7:0]                                seg_min_ones,
    output logic [7:0]                                seg_min_tens,
    output logic [7:0]                                seg_hour_ones,
    output logic [7:0]                                seg_hour_tens,
    output logic [15:0]                               time_bcd,
    output logic [4:0]                                hour_value,
    input  wire logic                                 cfg_we,
    input  wire logic [bcdcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bcdcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bcdcd_pkg::*;

    logic                    item_vld_reg;
    logic                    item_vld_next;
    logic                    op_reg;
    logic                    pend_reg;
    logic [SWITCH_COUNT-1:0] edges_reg;

    cfg_t       cfg;
    tk_result_t res;
    logic       adv;
    logic       upd;
    logic       load_in;

    // an item with no output may leave even while the output is stalled
    assign adv = !(out_valid && out_stall) || !res.has_result;
    assign upd = item_vld_reg && adv;
    assign in_stall = item_vld_reg && !adv;
    assign load_in = in_valid && !in_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (load_in)
        begin
            item_vld_next = 1'b1;
        end
        else if (adv)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            op_reg <= operation;
            pend_reg <= timer_pending;
            edges_reg <= switch_edges;
        end
    end

    bcdcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcdcd_timekeep #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_timekeep (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .operation     (op_reg),
        .timer_pending (pend_reg),
        .switch_edges  (edges_reg),
        .upd           (upd),
        .res           (res)
    );

    bcdcd_display u_display (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (upd && res.has_result),
        .tm            (res.tm),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .seg_sec_ones  (seg_sec_ones),
        .seg_sec_tens  (seg_sec_tens),
        .seg_min_ones  (seg_min_ones),
        .seg_min_tens  (seg_min_tens),
        .seg_hour_ones (seg_hour_ones),
        .seg_hour_tens (seg_hour_tens),
        .time_bcd      (time_bcd),
        .hour_value    (hour_value)
    );

endmodule

`default_nettype wire

[hw/rtl/bcdcd_checker.sv]
// port-level checks of the countdown clock display, bound to the top level
// depends on bcdcd_pkg and bcd_countdown_clock_display
`default_nettype none

module bcdcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] time_bcd,
    input wire logic [4:0]  hour_value
);
    import bcdcd_pkg::*;

    // a held output item keeps its time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(time_bcd))
    else $error("stalled output item changed");

    // with the output empty nothing can back up the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour_value <= HOUR_MAX)
    else $error("hour out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> time_bcd[3:0] <= 4'd9 && time_bcd[7:4] <= 4'd5
                      && time_bcd[11:8] <= 4'd9 && time_bcd[15:12] <= 4'd5)
    else $error("time digits out of range");

endmodule

bind bcd_countdown_clock_display bcdcd_checker u_bcdcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .time_bcd   (time_bcd),
    .hour_value (hour_value)
);

`default_nettype wire

[tb/bcd_countdown_clock_display_tb.sv]
// self-checking testbench for the countdown clock display: directed events, then random phases
// a scoreboard class predicts every display item; depends on bcdcd_pkg and the block's rtl
`default_nettype none

module bcd_countdown_clock_display_tb;
    import bcdcd_pkg::*;

    typedef struct packed {
        logic [7:0] digit0_seg;
        logic [7:0] digit1_seg;
        logic [7:0] digit2_seg;
        logic [7:0] digit3_seg;
        logic [7:0] hour_ones;
        logic [7:0] hour_tens;
        logic [15:0] minsec;
        logic [4:0] hour;
    } display_t;

    class countdown_scoreboard;
        cfg_t regs;
        logic [15:0] minsec;
        logic [4:0] hour;
        logic [7:0] ticks;
        display_t pending_displays[$];
        int mismatches;

        function new();
            regs.ticks_per_second = TPS_RESET;
            regs.switch_select = SELECT_RESET;
            regs.switch_step = STEP_RESET;
            minsec = MINSEC_RESET;
            hour = 5'd0;
            ticks = 8'd0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] value);
            case (idx)
                CFG_TICKS_PER_SECOND: regs.ticks_per_second = value;
                CFG_SWITCH_SELECT: regs.switch_select = value[3:0];
                CFG_SWITCH_STEP: regs.switch_step = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern(logic [3:0] digit);
            logic [7:0] segs [10];
            segs = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
            if (digit < 4'd10)
                return segs[digit];
            return SEG_BLANK;
        endfunction

        function void drop_second();
            logic [3:0] d0;
            logic [3:0] d1;
            logic [3:0] d2;
            logic [3:0] d3;
            {d3, d2, d1, d0} = minsec;
            if (d0 != 4'd0)
            begin
                d0 = d0 - 4'd1;
            end
            else if (d1 != 4'd0)
            begin
                d0 = 4'd9;
                d1 = d1 - 4'd1;
            end
            else if (d2 != 4'd0)
            begin
                d0 = 4'd9;
                d1 = 4'd5;
                d2 = d2 - 4'd1;
            end
            else if (d3 != 4'd0)
            begin
                d0 = 4'd9;
                d1 = 4'd5;
                d2 = 4'd9;
                d3 = d3 - 4'd1;
            end
            else
            begin
                // borrow from the hour at 00:00
                minsec = MINSEC_WRAP;
                hour = (hour == 5'd0) ? HOUR_MAX : hour - 5'd1;
                return;
            end
            minsec = {d3, d2, d1, d0};
        endfunction

        function void push_display();
            display_t d;
            logic [4:0] h_ones;
            logic [4:0] h_tens;
            h_ones = hour % 5'd10;
            h_tens = hour / 5'd10;
            d.digit0_seg = pattern(minsec[3:0]);
            d.digit1_seg = pattern(minsec[7:4]);
            d.digit2_seg = pattern(minsec[11:8]);
            d.digit3_seg = pattern(minsec[15:12]);
            d.hour_ones = pattern(h_ones[3:0]);
            d.hour_tens = pattern(h_tens[3:0]);
            d.minsec = minsec;
            d.hour = hour;
            pending_displays.push_back(d);
        endfunction

        function void take_event(logic op, logic pend, logic [SWITCH_COUNT_DEF-1:0] edges);
            if (op == OP_TIMER)
            begin
                if (!pend)
                    return;
                ticks = ticks + 8'd1;
                if (ticks != regs.ticks_per_second)
                    return;
                ticks = 8'd0;
                drop_second();
                push_display();
            end
            else
            begin
                if (regs.switch_select >= SWITCH_COUNT_DEF)
                    return;
                if (!edges[regs.switch_select])
                    return;
                for (int i = 0; i < regs.switch_step; i++)
                    drop_second();
                push_display();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", field, got, want));
        endtask

        task check_display(display_t got);
            display_t want;
            if (pending_displays.size() == 0)
            begin
                report("display item with nothing expected");
                return;
            end
            want = pending_displays.pop_front();
            compare_field("seg_sec_ones", 16'(got.digit0_seg), 16'(want.digit0_seg));
            compare_field("seg_sec_tens", 16'(got.digit1_seg), 16'(want.digit1_seg));
            compare_field("seg_min_ones", 16'(got.digit2_seg), 16'(want.digit2_seg));
            compare_field("seg_min_tens", 16'(got.digit3_seg), 16'(want.digit3_seg));
            compare_field("seg_hour_ones", 16'(got.hour_ones), 16'(want.hour_ones));
            compare_field("seg_hour_tens", 16'(got.hour_tens), 16'(want.hour_tens));
            compare_field("time_bcd", got.minsec, want.minsec);
            compare_field("hour_value", 16'(got.hour), 16'(want.hour));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_TIMER;
    logic timer_pending = 1'b0;
    logic [SWITCH_COUNT_DEF-1:0] switch_edges = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] seg_sec_ones;
    logic [7:0] seg_sec_tens;
    logic [7:0] seg_min_ones;
    logic [7:0] seg_min_tens;
    logic [7:0] seg_hour_ones;
    logic [7:0] seg_hour_tens;
    logic [15:0] time_bcd;
    logic [4:0] hour_value;
    logic cfg_we = 1'b0;
    cfg_idx_t cfg_index = CFG_TICKS_PER_SECOND;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    countdown_scoreboard book = new();

    bcd_countdown_clock_display #(
        .SWITCH_COUNT(SWITCH_COUNT_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .timer_pending(timer_pending),
        .switch_edges(switch_edges),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .seg_sec_ones(seg_sec_ones),
        .seg_sec_tens(seg_sec_tens),
        .seg_min_ones(seg_min_ones),
        .seg_min_tens(seg_min_tens),
        .seg_hour_ones(seg_hour_ones),
        .seg_hour_tens(seg_hour_tens),
        .time_bcd(time_bcd),
        .hour_value(hour_value),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("** bcd_countdown_clock_display: FAILED **");
        $finish;
    end

    // display side: check accepted items, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_display({seg_sec_ones, seg_sec_tens, seg_min_ones, seg_min_tens,
                                seg_hour_ones, seg_hour_tens, time_bcd, hour_value});
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic send_event(input logic op, input logic pend,
                              input logic [SWITCH_COUNT_DEF-1:0] edges);
        in_valid <= 1'b1;
        operation <= op;
        timer_pending <= pend;
        switch_edges <= edges;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        book.take_event(op, pend, edges);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // wait for every expected display, then for items that give none to drain
    task automatic settle();
        int waited;
        waited = 0;
        while (book.pending_displays.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        book.set_reg(idx, value);
    endtask

    task automatic set_clock_regs(input logic [7:0] tps, input logic [3:0] sel,
                                  input logic [3:0] step);
        in_valid <= 1'b0;
        settle();
        write_reg(CFG_TICKS_PER_SECOND, tps);
        write_reg(CFG_SWITCH_SELECT, {4'd0, sel});
        write_reg(CFG_SWITCH_STEP, {4'd0, step});
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed events that hit the selected switch or a pending tick
    task automatic run_phase(input int count, input int timer_w, input int pause_at);
        logic op;
        logic pend;
        logic [SWITCH_COUNT_DEF-1:0] edges;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
            begin
                in_valid <= 1'b0;
                settle();
            end
            edges = SWITCH_COUNT_DEF'($urandom_range(1023));
            if ($urandom_range(99) < timer_w)
            begin
                op = OP_TIMER;
                pend = ($urandom_range(99) < 90);
            end
            else
            begin
                op = OP_SWITCH;
                pend = 1'($urandom_range(1));
                if (book.regs.switch_select < SWITCH_COUNT_DEF)
                    edges[book.regs.switch_select] = ($urandom_range(99) < 90);
            end
            send_event(op, pend, edges);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ignored events, selected switch, full prescaler count
        send_event(OP_TIMER, 1'b0, 10'h3FF);
        send_event(OP_SWITCH, 1'b1, 10'h000);
        send_event(OP_SWITCH, 1'b0, 10'h002);
        send_event(OP_SWITCH, 1'b1, 10'h3FD);
        repeat (13) send_event(OP_TIMER, 1'b1, 10'h000);

        // select beyond the switches
        set_clock_regs(8'd2, 4'd12, 4'd0);
        send_event(OP_SWITCH, 1'b1, 10'h3FF);

        // zero step still gives an item
        set_clock_regs(8'd255, 4'd9, 4'd0);
        send_event(OP_SWITCH, 1'b1, 10'h200);
        send_event(OP_SWITCH, 1'b0, 10'h1FF);

        set_clock_regs(8'd1, 4'd0, 4'd15);
        idle_pct = 0;
        stall_pct = 0;
        run_phase(120, 25, -1);

        set_clock_regs(8'd255, 4'd9, 4'd15);
        idle_pct = 49;
        stall_pct = 0;
        run_phase(240, 85, -1);

        // prescaler count may now sit above the new limit
        set_clock_regs(8'd3, 4'd5, 4'd13);
        idle_pct = 0;
        stall_pct = 49;
        run_phase(120, 25, 60);

        set_clock_regs(8'd0, 4'd3, 4'd15);
        idle_pct = 25;
        stall_pct = 25;
        run_phase(120, 25, -1);

        in_valid <= 1'b0;
        settle();
        if (book.pending_displays.size() > 0)
            book.report($sformatf("%0d expected display items never arrived",
                                  book.pending_displays.size()));
        if (book.mismatches == 0)
            $display("** bcd_countdown_clock_display: PASSED **");
        else
            $display("** bcd_countdown_clock_display: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/bcdcd_pkg.sv
hw/rtl/bcdcd_cfg.sv
hw/rtl/bcdcd_timekeep.sv
hw/rtl/bcdcd_display.sv
hw/rtl/bcd_countdown_clock_display.sv
hw/rtl/bcdcd_checker.sv
tb/bcd_countdown_clock_display_tb.sv
